// ===== sv/mf2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared types and constants of the 2-D median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mf2d_pkg;

  localparam int PIX_W = 8;   // pixel width
  localparam int FW_W  = 11;  // frame_width register width
  localparam int FH_W  = 12;  // frame_height register width
  localparam int WIN_W = 3;   // window size register width
  localparam int CFG_W = 12;  // configuration data width

  // Register indexes of the configuration channel.
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_WINDOW_HEIGHT = 2'd2,
    CFG_WINDOW_WIDTH  = 2'd3
  } cfg_index_t;

  // Item kinds on the input stream.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input transfer takes place this cycle
    logic start;   // open the median search of the pending window
    logic step;    // read the next window pixel
    logic decide;  // settle one result bit
    logic emit;    // load the output register and advance
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_ready;  // every pixel of the pending window has arrived
    logic step_last;  // current read is the last one of a pass
    logic bit_last;   // the bit being settled is the lowest one
    logic out_free;   // output register can take a new result
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== sv/mf2d_ram.sv =====
// ----------------------------------------------------------------------------
// mf2d_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mf2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// mf2d_ctrl
// Sequencer of the median filter: takes one item, checks the window and
// runs the bitwise median search over the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module mf2d_ctrl
  import mf2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // Commands follow from the state and the status.
  always_comb begin
    cmd        = '0;
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.start  = (state == S_CHECK) && sts.win_ready;
    cmd.step   = (state == S_SCAN);
    cmd.decide = (state == S_DECIDE);
    cmd.emit   = (state == S_EMIT) && sts.out_free;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          state <= sts.win_ready ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (sts.step_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= sts.bit_last ? S_EMIT : S_SCAN;
        end
        S_EMIT: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A search never starts without a preceding input transfer check.
  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> $past(cmd.accept))
    else $error("median search started without a new item");

  // The last read of a pass is always followed by a decision, after the drain state.
  a_decide_after_pass: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.step_last) |-> ##2 cmd.decide)
    else $error("bit decision missing after a pass");

  // No input transfer while the search is busy.
  a_no_accept_in_search: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !in_ready)
    else $error("input accepted during a pass");

endmodule

`default_nettype wire

// ===== sv/mf2d_datapath.sv =====
// ----------------------------------------------------------------------------
// mf2d_datapath
// Frame counters, configuration, line store, window addressing with
// reflect-101 borders, bitwise median search and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mf2d_datapath
  import mf2d_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_cmd_t         cmd,
  output ctl_sts_t              sts,
  input  wire logic             in_op,
  input  wire logic [PIX_W-1:0] in_pixel,
  input  wire logic             cfg_valid,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [PIX_W-1:0] out_median,
  output logic                  out_last
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = CW + 1;
  localparam int XW   = (EW > FW_W) ? EW : FW_W;
  localparam int RB   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = RB + CW;
  localparam int HMAX = (MAX_WINDOW - 1) / 2;
  localparam int IW   = WIN_W + 1;
  localparam int NW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SW   = ((FH_W > EW) ? FH_W : EW) + 2;
  localparam int BW   = $clog2(PIX_W);

  // Configuration registers.
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [WIN_W-1:0] window_height;
  logic [WIN_W-1:0] window_width;

  // Frame position counters.
  logic [FH_W-1:0] in_row, out_row;
  logic [CW-1:0]   in_col, out_col;

  // Search state.
  logic [IW-1:0]    win_i, win_j;
  logic [BW-1:0]    bit_sel;
  logic [NW-1:0]    cnt, rank;
  logic [PIX_W-1:0] med;
  logic             rd_valid;

  // Effective frame and window sizes.
  logic [EW-1:0]    fw_eff;
  logic [FH_W-1:0]  fh_eff;
  logic [WIN_W-1:0] vh, vw, hh, hw;
  logic [NW-1:0]    n_cells;

  always_comb begin
    if (frame_width == '0) begin
      fw_eff = EW'(1);
    end else if (XW'(frame_width) > XW'(MAX_WIDTH)) begin
      fw_eff = EW'(MAX_WIDTH);
    end else begin
      fw_eff = EW'(frame_width);
    end
    fh_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
    vh = window_height >> 1;
    vw = window_width >> 1;
    hh = (vh > WIN_W'(HMAX)) ? WIN_W'(HMAX) : vh;
    hw = (vw > WIN_W'(HMAX)) ? WIN_W'(HMAX) : vw;
    n_cells = NW'({hh, 1'b0} + IW'(1)) * NW'({hw, 1'b0} + IW'(1));
  end

  // Window completeness: the last raster position it needs has arrived.
  logic [FH_W:0]   rr_sum;
  logic [EW:0]     rc_sum;
  logic [FH_W-1:0] rr;
  logic [EW-1:0]   rc;
  logic            win_ready;

  always_comb begin
    rr_sum = {1'b0, out_row} + (FH_W + 1)'(hh);
    rc_sum = {2'b0, out_col} + (EW + 1)'(hw);
    rr = (rr_sum > {1'b0, fh_eff - FH_W'(1)}) ? fh_eff - FH_W'(1) : rr_sum[FH_W-1:0];
    rc = (rc_sum > {1'b0, fw_eff - EW'(1)}) ? fw_eff - EW'(1) : rc_sum[EW-1:0];
    win_ready = (rr < in_row) || ((rr == in_row) && (rc < {1'b0, in_col}));
  end

  // Reflect-101 once, then clamp into the frame.
  function automatic logic signed [SW-1:0] mirror(input logic signed [SW-1:0] p,
                                                  input logic signed [SW-1:0] n);
    logic signed [SW-1:0] q;
    q = p;
    if (q < 0) q = -q;
    if (q >= n) q = ((n - 1) <<< 1) - q;
    if (q < 0) q = '0;
    if (q > n - 1) q = n - 1;
    return q;
  endfunction

  // Address of the window pixel being read.
  logic signed [SW-1:0] row_pos, col_pos, row_m, col_m;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    row_pos = SW'(out_row) - SW'(hh) + SW'(win_i);
    col_pos = SW'(out_col) - SW'(hw) + SW'(win_j);
    row_m   = mirror(row_pos, SW'(fh_eff));
    col_m   = mirror(col_pos, SW'(fw_eff));
    rd_addr = {row_m[RB-1:0], col_m[CW-1:0]};
  end

  // Line store write on a pixel transfer within the frame.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [PIX_W-1:0] rd_data;

  assign wr_en   = cmd.accept && (in_op == OP_PIXEL) && (in_row < fh_eff);
  assign wr_addr = {in_row[RB-1:0], in_col};

  mf2d_ram #(
    .WIDTH(PIX_W),
    .DEPTH(2 ** AW)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_pixel),
    .rd_en  (cmd.step),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Pass status.
  logic [PIX_W-1:0] hi_mask;
  logic             match;
  logic             frame_end;

  always_comb begin
    sts.win_ready = win_ready;
    sts.step_last = (win_i == {hh, 1'b0}) && (win_j == {hw, 1'b0});
    sts.bit_last  = (bit_sel == '0);
    sts.out_free  = !out_valid || out_ready;
    hi_mask   = ~(PIX_W'({PIX_W{1'b1}}) >> (BW'(PIX_W - 1) - bit_sel));
    match     = (((rd_data ^ med) & hi_mask) == '0) && !rd_data[bit_sel];
    frame_end = (out_row == fh_eff - FH_W'(1)) && ({1'b0, out_col} == fw_eff - EW'(1));
  end

  // Configuration, counters, search and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_W'(640);
      frame_height  <= FH_W'(480);
      window_height <= WIN_W'(7);
      window_width  <= WIN_W'(7);
      in_row        <= '0;
      in_col        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= cmd.step;

      // Configuration write restarts the frame.
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_FRAME_WIDTH:   frame_width   <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[FH_W-1:0];
          CFG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_W-1:0];
          CFG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_W-1:0];
          default: begin
          end
        endcase
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end

      // Input position advances with each stored pixel.
      if (wr_en) begin
        if ({1'b0, in_col} + EW'(1) >= fw_eff) begin
          in_col <= '0;
          in_row <= in_row + FH_W'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end

      // Output transfer clears the register.
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Result goes out; output position advances or the frame restarts.
      if (cmd.emit) begin
        out_valid  <= 1'b1;
        out_median <= med;
        out_last   <= frame_end;
        if (frame_end) begin
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
        end else if ({1'b0, out_col} + EW'(1) >= fw_eff) begin
          out_col <= '0;
          out_row <= out_row + FH_W'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // Median search: settle one bit per pass, from the top bit down.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bit_sel <= BW'(PIX_W - 1);
      rank    <= n_cells >> 1;
      med     <= '0;
      cnt     <= '0;
      win_i   <= '0;
      win_j   <= '0;
    end else begin
      if (cmd.step) begin
        if (win_j == {hw, 1'b0}) begin
          win_j <= '0;
          win_i <= win_i + IW'(1);
        end else begin
          win_j <= win_j + IW'(1);
        end
      end
      if (rd_valid && match) begin
        cnt <= cnt + NW'(1);
      end
      if (cmd.decide) begin
        if (cnt <= rank) begin
          rank         <= rank - cnt;
          med[bit_sel] <= 1'b1;
        end
        bit_sel <= bit_sel - BW'(1);
        cnt     <= '0;
        win_i   <= '0;
        win_j   <= '0;
      end
    end
  end

  // Line store is never written and read in the same cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && cmd.step))
    else $error("line store write during a pass");

  // The match count of a pass never exceeds the window size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (cnt <= n_cells))
    else $error("median count above window size");

  // A new result appears only through an emit command.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result appeared without emit");

endmodule

`default_nettype wire

// ===== sv/median_filter_2d_top.sv =====
// ----------------------------------------------------------------------------
// median_filter_2d_top
// 2-D median filter for an 8-bit grayscale stream with reflect-101 borders.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata: pixel_in; tuser: op (0 pixel, 1 drain)
//  m_axis    out        tdata: median_out; tlast: frame_last
//  cfg       in         cfg_index: register, cfg_data: value
//
//  An item that yields no result passes through the idle and check states
//  only. For a result, the single line store read port is swept over the
//  window once per result bit.
//  Reset is synchronous; no clearing pass is needed.
//  A result waiting on m_axis does not stop the next transfer on s_axis;
//  only loading the following result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_2d_top
  import mf2d_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel_in
  input  wire logic             s_axis_tuser,   // [0] op
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [PIX_W-1:0] m_axis_tdata,   // [7:0] median_out
  output logic                  m_axis_tlast,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Configuration writes are taken at once.
  assign cfg_ready = 1'b1;

  mf2d_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mf2d_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_axis_tuser),
    .in_pixel  (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_median(m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
